/* rtl/core/vcsd_pkg.sv */
// Shared types, widths and codes of the CAN signal decoder.
package vcsd_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int ID_W          = 11;
    localparam int NBYTES        = 8;
    localparam int IN_W          = 80;
    localparam int VAL_W         = 40;
    localparam int CODE_W        = 5;
    localparam int USER_W        = 6;
    localparam int MAG_IN_W      = 24;
    localparam int DIV_IN_W      = 17;
    localparam int DIVISOR_W     = 13;
    localparam int SLOTS         = 4;
    localparam int CNT_W         = 3;
    localparam int IDX_W         = 2;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_W         = 2;

    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODEL_CLASS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MODEL_KNOWN = 1'b1;

    // frame identifiers
    localparam logic [ID_W-1:0] ID_STEER    = 11'h002;
    localparam logic [ID_W-1:0] ID_BODY     = 11'h60D;
    localparam logic [ID_W-1:0] ID_GEAR     = 11'h421;
    localparam logic [ID_W-1:0] ID_POWER    = 11'h260;
    localparam logic [ID_W-1:0] ID_SPEED    = 11'h284;
    localparam logic [ID_W-1:0] ID_TURN     = 11'h358;
    localparam logic [ID_W-1:0] ID_LAMPS    = 11'h625;
    localparam logic [ID_W-1:0] ID_CLIMATE  = 11'h54B;
    localparam logic [ID_W-1:0] ID_CLIM_ST  = 11'h510;
    localparam logic [ID_W-1:0] ID_CRUISE   = 11'h551;
    localparam logic [ID_W-1:0] ID_BATT     = 11'h5C0;
    localparam logic [ID_W-1:0] ID_BRAKE    = 11'h5C5;

    // signal codes
    localparam logic [CODE_W-1:0] SIG_STEER      = 5'd0;
    localparam logic [CODE_W-1:0] SIG_IGNITION   = 5'd1;
    localparam logic [CODE_W-1:0] SIG_LOCK       = 5'd2;
    localparam logic [CODE_W-1:0] SIG_GEAR       = 5'd3;
    localparam logic [CODE_W-1:0] SIG_MOTOR_PWR  = 5'd4;
    localparam logic [CODE_W-1:0] SIG_SPEED      = 5'd5;
    localparam logic [CODE_W-1:0] SIG_TURN       = 5'd6;
    localparam logic [CODE_W-1:0] SIG_LAMPS      = 5'd7;
    localparam logic [CODE_W-1:0] SIG_CLIMATE_ON = 5'd8;
    localparam logic [CODE_W-1:0] SIG_FAN        = 5'd9;
    localparam logic [CODE_W-1:0] SIG_AMBIENT    = 5'd10;
    localparam logic [CODE_W-1:0] SIG_CLIM_PWR   = 5'd11;
    localparam logic [CODE_W-1:0] SIG_AUX_PWR    = 5'd12;
    localparam logic [CODE_W-1:0] SIG_CHARGE     = 5'd13;
    localparam logic [CODE_W-1:0] SIG_CRUISE_ST  = 5'd14;
    localparam logic [CODE_W-1:0] SIG_CRUISE_SPD = 5'd15;
    localparam logic [CODE_W-1:0] SIG_BATT_TEMP  = 5'd16;
    localparam logic [CODE_W-1:0] SIG_PARK_BRAKE = 5'd17;
    localparam logic [CODE_W-1:0] SIG_ODOMETER   = 5'd18;

    // scaling of the raw magnitude: value = mag * 2^FRACTION_BITS / divisor
    typedef enum logic [3:0] {
        DIV_1, DIV_2, DIV_4, DIV_8, DIV_10, DIV_20, DIV_200, DIV_416, DIV_6000
    } t_div;

    typedef struct packed {
        logic [CODE_W-1:0]   code;
        logic [MAG_IN_W-1:0] mag;
        logic                neg;
        logic                absent;
        t_div                div;
        logic                last;
    } t_slot;

    typedef struct packed {
        logic [CFG_W-1:0] model_class;
        logic             model_known;
    } t_cfg;

endpackage

/* rtl/core/vcsd_front.sv */
// Frame decode into up to four signal requests, one per cycle out while taken.
module vcsd_front
    import vcsd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  logic                    i_vld,
    output logic                    o_rdy,
    input  logic [ID_W-1:0]         i_id,
    input  logic [NBYTES-1:0][7:0]  i_bytes,
    output logic                    o_vld,
    input  logic                    i_rdy,
    output t_slot                   o_slot
);

    localparam logic [15:0] STEER_FULL   = 16'd6000;
    localparam logic [12:0] PWR_OFS_NEW  = 13'd2000;
    localparam logic [12:0] PWR_OFS_OLD  = 13'd400;
    localparam logic [7:0]  TEMP_OFS     = 8'd80;
    localparam logic [7:0]  CRUISE_NA    = 8'd254;
    localparam logic [7:0]  TEMP_NA      = 8'hFF;
    localparam int          CRU_SHIFT    = 19;
    localparam int          CRU_PW       = 27;
    // 91/100 as a reciprocal product, exact for every byte value below 254
    localparam logic [CRU_PW-1:0] CRU_RECIP = 27'd477113;

    function automatic t_slot mk(input logic [CODE_W-1:0] code,
                                 input logic [MAG_IN_W-1:0] mag,
                                 input logic neg, input logic absent, input t_div div);
        t_slot s;
        s.code   = code;
        s.mag    = mag;
        s.neg    = neg;
        s.absent = absent;
        s.div    = div;
        s.last   = 1'b0;
        return s;
    endfunction

    logic [15:0]         steer_u;
    logic [15:0]         steer_abs;
    logic                steer_hi;
    logic                steer_lo;
    logic                pwr_fresh;
    logic [12:0]         pwr_dlt;
    logic                pwr_neg;
    logic [11:0]         pwr_abs;
    logic [13:0]         pwr_abs3;
    logic [16:0]         spd_sum;
    logic                amb_lo;
    logic [7:0]          amb_abs;
    logic                bat_lo;
    logic [7:0]          bat_abs;
    logic [CRU_PW-1:0]   cru_prod;
    logic [2:0]          cru_st;
    logic [1:0]          cru_cs;
    logic [1:0]          gear;

    t_slot               n_slots [SLOTS];
    logic [CNT_W-1:0]    n_cnt;

    t_slot               r_slots [SLOTS];
    logic [CNT_W-1:0]    r_cnt;
    logic [IDX_W-1:0]    r_idx;
    logic                r_vld;

    logic                take;
    logic                last_slot;
    logic                acc;
    t_slot               cur;

    assign steer_u   = {i_bytes[1], i_bytes[0]};
    assign steer_abs = steer_u[15] ? (~steer_u + 16'd1) : steer_u;
    assign steer_hi  = !steer_u[15] && (steer_u >= STEER_FULL);
    assign steer_lo  = steer_u[15] && (steer_abs >= STEER_FULL);

    assign pwr_fresh = (i_cfg.model_class != '0);
    assign pwr_dlt   = {1'b0, i_bytes[2], i_bytes[3][7:4]}
                       - (pwr_fresh ? PWR_OFS_NEW : PWR_OFS_OLD);
    assign pwr_neg   = pwr_dlt[12];
    assign pwr_abs   = pwr_neg ? 12'(~pwr_dlt + 13'd1) : pwr_dlt[11:0];
    assign pwr_abs3  = {2'b00, pwr_abs} + {1'b0, pwr_abs, 1'b0};

    assign spd_sum   = {1'b0, i_bytes[0], i_bytes[1]} + {1'b0, i_bytes[2], i_bytes[3]};

    assign amb_lo    = i_bytes[7] < TEMP_OFS;
    assign amb_abs   = amb_lo ? (TEMP_OFS - i_bytes[7]) : (i_bytes[7] - TEMP_OFS);
    assign bat_lo    = i_bytes[2] < TEMP_OFS;
    assign bat_abs   = bat_lo ? (TEMP_OFS - i_bytes[2]) : (i_bytes[2] - TEMP_OFS);

    assign cru_prod  = CRU_PW'(i_bytes[4]) * CRU_RECIP;
    assign cru_st    = i_bytes[5][6:4];
    assign cru_cs    = (cru_st == 3'd5) ? 2'd1 : ((cru_st == 3'd4) ? 2'd2 : 2'd0);

    always_comb begin
        case (i_bytes[0])
            8'd16:        gear = 2'd1;
            8'd24:        gear = 2'd2;
            8'd32, 8'd56: gear = 2'd3;
            default:      gear = 2'd0;
        endcase
    end

    always_comb begin
        for (int k = 0; k < SLOTS; k++) begin
            n_slots[k] = '0;
        end
        n_cnt = '0;
        case (i_id)
            ID_STEER: begin
                if (steer_hi || steer_lo) begin
                    n_slots[0] = mk(SIG_STEER, MAG_IN_W'(1), steer_lo, 1'b0, DIV_1);
                end else begin
                    n_slots[0] = mk(SIG_STEER, MAG_IN_W'(steer_abs), steer_u[15], 1'b0,
                                    DIV_6000);
                end
                n_cnt = 3'd1;
            end
            ID_BODY: begin
                n_slots[0] = mk(SIG_IGNITION, MAG_IN_W'(i_bytes[1][2]), 1'b0, 1'b0, DIV_1);
                n_slots[1] = mk(SIG_LOCK, MAG_IN_W'(i_bytes[2][3]), 1'b0, 1'b0, DIV_1);
                n_cnt = 3'd2;
            end
            ID_GEAR: begin
                n_slots[0] = mk(SIG_GEAR, MAG_IN_W'(gear), 1'b0, 1'b0, DIV_1);
                n_cnt = 3'd1;
            end
            ID_POWER: begin
                if (i_cfg.model_known) begin
                    if (!pwr_fresh) begin
                        n_slots[0] = mk(SIG_MOTOR_PWR, MAG_IN_W'(pwr_abs), pwr_neg, 1'b0,
                                        DIV_8);
                    end else if (pwr_neg) begin
                        // negative power: x * 15 / 1000 == 3x / 200
                        n_slots[0] = mk(SIG_MOTOR_PWR, MAG_IN_W'(pwr_abs3), 1'b1, 1'b0,
                                        DIV_200);
                    end else begin
                        n_slots[0] = mk(SIG_MOTOR_PWR, MAG_IN_W'(pwr_abs), 1'b0, 1'b0,
                                        DIV_20);
                    end
                    n_cnt = 3'd1;
                end
            end
            ID_SPEED: begin
                n_slots[0] = mk(SIG_SPEED, MAG_IN_W'(spd_sum), 1'b0, 1'b0, DIV_416);
                n_cnt = 3'd1;
            end
            ID_TURN: begin
                n_slots[0] = mk(SIG_TURN, MAG_IN_W'(i_bytes[2][2:1]), 1'b0, 1'b0, DIV_1);
                n_cnt = 3'd1;
            end
            ID_LAMPS: begin
                n_slots[0] = mk(SIG_LAMPS, MAG_IN_W'(i_bytes[1][5]), 1'b0, 1'b0, DIV_1);
                n_cnt = 3'd1;
            end
            ID_CLIMATE: begin
                n_slots[0] = mk(SIG_CLIMATE_ON, MAG_IN_W'(i_bytes[1][6]), 1'b0, 1'b0, DIV_1);
                n_slots[1] = mk(SIG_FAN, MAG_IN_W'(i_bytes[4][7:3]), 1'b0, 1'b0, DIV_1);
                n_cnt = 3'd2;
            end
            ID_CLIM_ST: begin
                n_slots[0] = mk(SIG_AMBIENT, MAG_IN_W'(amb_abs), amb_lo,
                                i_bytes[7] == TEMP_NA, DIV_2);
                n_slots[1] = mk(SIG_CLIM_PWR, MAG_IN_W'(i_bytes[3][6:1]), 1'b0, 1'b0, DIV_4);
                n_slots[2] = mk(SIG_AUX_PWR, MAG_IN_W'(i_bytes[4][7:3]), 1'b0, 1'b0, DIV_10);
                n_slots[3] = mk(SIG_CHARGE, MAG_IN_W'(i_bytes[1][2:0]), 1'b0, 1'b0, DIV_1);
                n_cnt = 3'd4;
            end
            ID_CRUISE: begin
                n_slots[0] = mk(SIG_CRUISE_ST, MAG_IN_W'(cru_cs), 1'b0, 1'b0, DIV_1);
                if (i_bytes[4] < CRUISE_NA) begin
                    n_slots[1] = mk(SIG_CRUISE_SPD, MAG_IN_W'(cru_prod[CRU_PW-1:CRU_SHIFT]),
                                    1'b0, 1'b0, DIV_1);
                end else begin
                    n_slots[1] = mk(SIG_CRUISE_SPD, '0, 1'b0, 1'b1, DIV_1);
                end
                n_cnt = 3'd2;
            end
            ID_BATT: begin
                n_slots[0] = mk(SIG_BATT_TEMP, MAG_IN_W'(bat_abs), bat_lo,
                                i_bytes[0][7:6] != 2'b01, DIV_2);
                n_cnt = 3'd1;
            end
            ID_BRAKE: begin
                n_slots[0] = mk(SIG_PARK_BRAKE, MAG_IN_W'(i_bytes[0][2]), 1'b0, 1'b0, DIV_1);
                n_slots[1] = mk(SIG_ODOMETER, {i_bytes[1], i_bytes[2], i_bytes[3]},
                                1'b0, 1'b0, DIV_1);
                n_cnt = 3'd2;
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    assign take      = r_vld && i_rdy;
    assign last_slot = ({1'b0, r_idx} == (r_cnt - 3'd1));
    assign o_rdy     = !r_vld || (take && last_slot);
    assign acc       = i_vld && o_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_idx <= '0;
        end else if (acc) begin
            // frames with no known signal are dropped here
            r_vld <= (n_cnt != '0);
            r_idx <= '0;
        end else if (take) begin
            if (last_slot) begin
                r_vld <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_slots <= n_slots;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        cur      = r_slots[r_idx];
        cur.last = last_slot;
    end

    assign o_vld  = r_vld;
    assign o_slot = cur;

endmodule

/* rtl/core/vcsd_arith.sv */
// Fixed-point scaling pipeline: reciprocal multiply, remainder check, sign and saturation.
module vcsd_arith
    import vcsd_pkg::*;
#(
    parameter int FRACTION_BITS = FRAC_BITS_DEF
)
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    output logic                    o_rdy,
    input  t_slot                   i_slot,
    output logic                    o_vld,
    input  logic                    i_rdy,
    output logic [CODE_W-1:0]       o_code,
    output logic signed [VAL_W-1:0] o_value,
    output logic                    o_absent,
    output logic                    o_last
);

    localparam int FB  = FRACTION_BITS;
    localparam int RS  = DIV_IN_W;          // reciprocal precision shift
    localparam int MW  = FB + 14;           // widest reciprocal is for divide by 10
    localparam int PW  = DIV_IN_W + MW;
    localparam int QW  = FB + 10;
    localparam int XW  = FB + DIV_IN_W;
    localparam int AW  = FB + MAG_IN_W;
    localparam int PRW = QW + DIVISOR_W;
    localparam int EW  = (AW > VAL_W) ? AW : VAL_W;

    localparam logic [MW-1:0] RCP_10   = MW'((64'd1 << (FB + RS)) / 10);
    localparam logic [MW-1:0] RCP_20   = MW'((64'd1 << (FB + RS)) / 20);
    localparam logic [MW-1:0] RCP_200  = MW'((64'd1 << (FB + RS)) / 200);
    localparam logic [MW-1:0] RCP_416  = MW'((64'd1 << (FB + RS)) / 416);
    localparam logic [MW-1:0] RCP_6000 = MW'((64'd1 << (FB + RS)) / 6000);

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              neg;
        logic              absent;
        t_div              div;
        logic              last;
    } t_tag;

    function automatic logic is_div(input t_div d);
        logic r;
        case (d)
            DIV_10, DIV_20, DIV_200, DIV_416, DIV_6000: r = 1'b1;
            default:                                    r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [MW-1:0] recip(input t_div d);
        logic [MW-1:0] r;
        case (d)
            DIV_10:   r = RCP_10;
            DIV_20:   r = RCP_20;
            DIV_200:  r = RCP_200;
            DIV_416:  r = RCP_416;
            DIV_6000: r = RCP_6000;
            default:  r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [DIVISOR_W-1:0] dval(input t_div d);
        logic [DIVISOR_W-1:0] r;
        case (d)
            DIV_10:   r = 13'd10;
            DIV_20:   r = 13'd20;
            DIV_200:  r = 13'd200;
            DIV_416:  r = 13'd416;
            DIV_6000: r = 13'd6000;
            default:  r = 13'd1;
        endcase
        return r;
    endfunction

    // stage 1: estimate quotient, scale exact cases
    logic               r1_vld;
    t_tag               r1_tag;
    logic [QW-1:0]      r1_q0;
    logic [AW-1:0]      r1_x;
    logic [PW-1:0]      p1;
    logic [AW-1:0]      n1_x;
    t_tag               n1_tag;

    // stage 2: quotient times divisor
    logic               r2_vld;
    t_tag               r2_tag;
    logic [QW-1:0]      r2_q0;
    logic [AW-1:0]      r2_x;
    logic [PRW-1:0]     r2_prod;

    // stage 3: one correction step
    logic               r3_vld;
    t_tag               r3_tag;
    logic [AW-1:0]      r3_mag;
    logic [XW-1:0]      rem3;
    logic               up3;
    logic [QW-1:0]      q3;
    logic               div3;

    // stage 4: output register
    logic               r4_vld;
    logic [CODE_W-1:0]  r4_code;
    logic [VAL_W-1:0]   r4_val;
    logic               r4_absent;
    logic               r4_last;
    logic [EW-1:0]      ext4;
    logic [VAL_W-1:0]   mag4;
    logic [VAL_W-1:0]   n4_val;

    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4  = !r4_vld || i_rdy;
    assign rdy3  = !r3_vld || rdy4;
    assign rdy2  = !r2_vld || rdy3;
    assign rdy1  = !r1_vld || rdy2;
    assign o_rdy = rdy1;

    assign n1_tag = '{code: i_slot.code, neg: i_slot.neg, absent: i_slot.absent,
                      div: i_slot.div, last: i_slot.last};
    assign p1 = PW'(i_slot.mag[DIV_IN_W-1:0]) * PW'(recip(i_slot.div));

    always_comb begin
        case (i_slot.div)
            DIV_1:   n1_x = AW'(i_slot.mag) << FB;
            DIV_2:   n1_x = AW'(i_slot.mag) << (FB - 1);
            DIV_4:   n1_x = AW'(i_slot.mag) << (FB - 2);
            DIV_8:   n1_x = AW'(i_slot.mag) << (FB - 3);
            default: n1_x = AW'(i_slot.mag[DIV_IN_W-1:0]) << FB;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            if (rdy1) begin
                r1_vld <= i_vld;
            end
            if (rdy2) begin
                r2_vld <= r1_vld;
            end
            if (rdy3) begin
                r3_vld <= r2_vld;
            end
            if (rdy4) begin
                r4_vld <= r3_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_vld) begin
            r1_tag <= n1_tag;
            r1_q0  <= p1[RS+QW-1:RS];
            r1_x   <= n1_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r1_vld) begin
            r2_tag  <= r1_tag;
            r2_q0   <= r1_q0;
            r2_x    <= r1_x;
            r2_prod <= PRW'(r1_q0) * PRW'(dval(r1_tag.div));
        end
    end

    assign div3 = is_div(r2_tag.div);
    assign rem3 = r2_x[XW-1:0] - r2_prod[XW-1:0];
    assign up3  = rem3 >= XW'(dval(r2_tag.div));
    assign q3   = r2_q0 + QW'(up3);

    always_ff @(posedge i_clk) begin
        if (rdy3 && r2_vld) begin
            r3_tag <= r2_tag;
            r3_mag <= div3 ? AW'(q3) : r2_x;
        end
    end

    assign ext4 = EW'(r3_mag);
    assign mag4 = (ext4 > EW'(VAL_MAX)) ? VAL_MAX : ext4[VAL_W-1:0];

    always_comb begin
        if (r3_tag.absent) begin
            n4_val = '0;
        end else if (r3_tag.neg) begin
            n4_val = ~mag4 + 40'd1;
        end else begin
            n4_val = mag4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4 && r3_vld) begin
            r4_code   <= r3_tag.code;
            r4_val    <= n4_val;
            r4_absent <= r3_tag.absent;
            r4_last   <= r3_tag.last;
        end
    end

    assign o_vld    = r4_vld;
    assign o_code   = r4_code;
    assign o_value  = $signed(r4_val);
    assign o_absent = r4_absent;
    assign o_last   = r4_last;

`ifndef ASSERT_OFF
    a_estimate_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r2_vld && div3) |-> (r2_prod <= PRW'(r2_x[XW-1:0])))
        else $error("quotient estimate above true quotient");

    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r2_vld && div3) |-> (rem3 < XW'({dval(r2_tag.div), 1'b0})))
        else $error("remainder needs more than one correction");

    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r4_vld && r4_absent) |-> (r4_val == '0))
        else $error("absent result carries a nonzero value");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r1_vld && !r4_vld))
        else $error("pipeline not empty after reset");
`endif

endmodule

/* rtl/core/vehicle_can_signal_decoder_unit.sv */
// Top level of the CAN signal decoder: configuration registers, decode front, scaling pipeline.
//
// Usage:
//   s_axis carries one received standard frame per request: identifier and eight
//   data bytes. m_axis gives the decoded signals, one per request: tuser holds the
//   signal code and an absent flag, tdata the signed value with FRACTION_BITS
//   fraction bits, tlast marks the final signal of a frame. Unknown identifiers,
//   and power frames while the model is not known, give nothing.
//   i_cfg_we/i_cfg_idx/i_cfg_wdata write model class (0) and model known (1);
//   write them only while no frame is in flight.
// Timing:
//   A frame's first signal reaches m_axis through the front register and the four
//   scaling stages. The front register hands out one signal per cycle while taken and
//   holds the input until the last of its frame's 1 to 4 signals is taken; sustained
//   output is one signal per cycle through the four-stage pipeline while m_axis is ready.
// Reset and stalls:
//   Reset empties all stages and clears both configuration registers. When m_axis
//   stalls, each stage holds its request; empty stages still fill from upstream,
//   but s_axis is ready only while the front register is empty or its frame's last signal is taken.
module vehicle_can_signal_decoder_unit
    import vcsd_pkg::*;
#(
    parameter int FRACTION_BITS = FRAC_BITS_DEF
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_W-1:0]      s_axis_tdata,   // frame_id, byte_0 .. byte_7, zero pad
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [VAL_W-1:0]     m_axis_tdata,   // signal_value
    output logic [USER_W-1:0]    m_axis_tuser,   // signal_code, value_absent
    output logic                 m_axis_tlast
);

    t_cfg                    r_cfg;
    logic [ID_W-1:0]         id;
    logic [NBYTES-1:0][7:0]  bytes;
    logic                    slot_vld;
    logic                    slot_rdy;
    t_slot                   slot;
    logic [CODE_W-1:0]       code;
    logic signed [VAL_W-1:0] value;
    logic                    absent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODEL_CLASS: r_cfg.model_class <= i_cfg_wdata;
                REG_MODEL_KNOWN: r_cfg.model_known <= i_cfg_wdata[0];
                default:         r_cfg <= r_cfg;
            endcase
        end
    end

    assign id    = s_axis_tdata[ID_W-1:0];
    assign bytes = s_axis_tdata[ID_W +: NBYTES*8];

    vcsd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_vld   (s_axis_tvalid),
        .o_rdy   (s_axis_tready),
        .i_id    (id),
        .i_bytes (bytes),
        .o_vld   (slot_vld),
        .i_rdy   (slot_rdy),
        .o_slot  (slot)
    );

    vcsd_arith #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (slot_vld),
        .o_rdy    (slot_rdy),
        .i_slot   (slot),
        .o_vld    (m_axis_tvalid),
        .i_rdy    (m_axis_tready),
        .o_code   (code),
        .o_value  (value),
        .o_absent (absent),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = value;
    assign m_axis_tuser = {absent, code};

endmodule
